FILE: hw/rtl/aecf_pkg.sv
// Shared widths, register map and gain constants for the echo comb filter.
// No dependencies; imported by the top level and its checker.
package aecf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int DELAY_W  = 12;
    localparam int REGION_W = 24;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int SUM_W    = 34;
    localparam int FRAC_W   = 15;

    localparam logic [GAIN_W:0] GAIN_ONE = 17'd32768;

    typedef enum logic [2:0] {
        REG_ECHO_GAIN     = 3'd0,
        REG_DELAY_SAMPLES = 3'd1,
        REG_FEEDBACK_MODE = 3'd2,
        REG_REGION_BEGIN  = 3'd3,
        REG_REGION_END    = 3'd4
    } t_reg_idx;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

FILE: hw/rtl/audio_echo_comb_filter.sv
// Echo comb filter top level: APB register file, delay-line memory, 3-stage mix pipeline.
// Depends on aecf_pkg.

// One sample beat is accepted every cycle while the output side keeps up; its result goes
// through the stage-1, stage-2 and output registers. The delay line is a single-port-write,
// single-port-read synchronous RAM of DELAY_DEPTH entries, one read and one write per beat.
// In feedback mode a delay of one sample closes a loop through one 18x16 multiply, the add,
// truncation and the forwarding mux combinationally; that path sets the clock. No clearing
// pass is needed after reset: entries older than the sample index read as zero by compare.
module audio_echo_comb_filter
    import aecf_pkg::*;
#(
    parameter int DELAY_DEPTH = 4096,
    parameter int INDEX_BITS  = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
    input  logic                s_axis_tuser,   // [0] is_flush
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,   // [15:0] out_sample
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int PW = $clog2(DELAY_DEPTH);
    localparam int DW = (PW > DELAY_W) ? PW : DELAY_W;
    localparam int CW = (INDEX_BITS > REGION_W + 1) ? INDEX_BITS : REGION_W + 1;
    localparam logic [DW-1:0]         D_MAX   = DW'(DELAY_DEPTH - 1);
    localparam logic [PW-1:0]         WP_LAST = PW'(DELAY_DEPTH - 1);
    localparam logic [PW:0]           DEPTH_X = (PW+1)'(DELAY_DEPTH);
    localparam logic [INDEX_BITS-1:0] T_MAX   = '1;

    // configuration
    logic [GAIN_W-1:0]   r_gain;
    logic [DELAY_W-1:0]  r_delay;
    logic                r_fb;
    logic [REGION_W-1:0] r_begin;
    logic [REGION_W-1:0] r_end;
    logic                wr_en;
    t_reg_idx            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= '0;
            r_delay <= DELAY_W'(1);
            r_fb    <= 1'b1;
            r_begin <= '0;
            r_end   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ECHO_GAIN:     r_gain  <= pwdata[GAIN_W-1:0];
                REG_DELAY_SAMPLES: r_delay <= pwdata[DELAY_W-1:0];
                REG_FEEDBACK_MODE: r_fb    <= pwdata[0];
                REG_REGION_BEGIN:  r_begin <= pwdata[REGION_W-1:0];
                REG_REGION_END:    r_end   <= pwdata[REGION_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_ECHO_GAIN:     prdata = APB_DW'(r_gain);
            REG_DELAY_SAMPLES: prdata = APB_DW'(r_delay);
            REG_FEEDBACK_MODE: prdata = APB_DW'(r_fb);
            REG_REGION_BEGIN:  prdata = APB_DW'(r_begin);
            REG_REGION_END:    prdata = APB_DW'(r_end);
            default:           prdata = '0;
        endcase
    end

    // derived settings
    logic [GAIN_W:0] g_eff;
    logic [GAIN_W:0] g_inv;
    logic [DW-1:0]   d_ext;
    logic [DW-1:0]   d_cl;
    logic [PW-1:0]   d_p;

    assign g_eff = ({1'b0, r_gain} > GAIN_ONE) ? GAIN_ONE : {1'b0, r_gain};
    assign g_inv = GAIN_ONE - g_eff;
    assign d_ext = DW'(r_delay);
    assign d_cl  = (d_ext == '0) ? DW'(1) : ((d_ext > D_MAX) ? D_MAX : d_ext);
    assign d_p   = d_cl[PW-1:0];

    // pipeline control
    logic adv;
    logic acc;
    logic r_out_vld;

    assign adv           = !r_out_vld || m_axis_tready;
    assign acc           = s_axis_tvalid && adv;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_out_vld;

    // stage 0: index, pointers, region decode
    logic [INDEX_BITS-1:0] r_t;
    logic [PW-1:0]         r_wp;
    logic [PW:0]           rp_wrap;
    logic [PW-1:0]         rp_in;
    logic [CW-1:0]         t_c;
    logic [CW-1:0]         d_c;
    logic [CW-1:0]         b_c;
    logic [CW-1:0]         e_c;
    logic                  dl_ok;
    logic                  pass;
    logic                  cur_z;
    t_sample               x_in;

    assign rp_wrap = {1'b0, r_wp} + DEPTH_X - {1'b0, d_p};
    assign rp_in   = (r_wp >= d_p) ? (r_wp - d_p) : rp_wrap[PW-1:0];
    assign t_c     = CW'(r_t);
    assign d_c     = CW'(d_cl);
    assign b_c     = (r_begin > r_end) ? '0 : CW'(r_begin);
    assign e_c     = CW'(r_end);
    assign dl_ok   = t_c >= d_c;
    assign pass    = (t_c < b_c) || (t_c >= e_c + d_c);
    assign cur_z   = !(t_c < e_c);
    assign x_in    = s_axis_tuser ? t_sample'(0) : t_sample'(s_axis_tdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t  <= '0;
            r_wp <= '0;
        end else if (acc) begin
            if (r_t != T_MAX) r_t <= r_t + INDEX_BITS'(1);
            r_wp <= (r_wp == WP_LAST) ? '0 : r_wp + PW'(1);
        end
    end

    // stage 1: memory data, forwarding, current-sample product
    logic          r1_vld;
    t_sample       r1_x;
    logic          r1_fb;
    logic          r1_pass;
    logic          r1_curz;
    logic          r1_dlok;
    logic [PW-1:0] r1_rp;
    logic [PW-1:0] r1_wp;
    t_sample       r_rd;

    // stage 2: echo product, mix, write-back
    logic                    r2_vld;
    t_sample                 r2_x;
    logic                    r2_fb;
    logic                    r2_pass;
    logic [PW-1:0]           r2_wp;
    logic signed [SUM_W-1:0] r2_a;
    t_sample                 r2_dl;

    // most recent write, covers a read issued on the same edge
    logic          r_lw_vld;
    logic [PW-1:0] r_lw_addr;
    t_sample       r_lw_data;

    logic [SAMPLE_W-1:0] r_mem [DELAY_DEPTH];
    logic [SAMPLE_W-1:0] r_out_data;

    t_sample                 cur1;
    logic signed [GAIN_W+1:0] ginv_s;
    logic signed [SUM_W-1:0] a_prod;
    t_sample                 dl_fwd;
    t_sample                 dl1;
    logic signed [GAIN_W+1:0] g_s;
    logic signed [SUM_W-1:0] g_prod;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-FRAC_W-1:0] q_fl;
    logic signed [SUM_W-FRAC_W-1:0] q;
    t_sample                 mix;
    t_sample                 y2;
    t_sample                 st2;

    assign cur1   = r1_curz ? t_sample'(0) : r1_x;
    assign ginv_s = {1'b0, g_inv};
    assign a_prod = ginv_s * cur1;

    always_comb begin
        priority if (r2_vld && (r2_wp == r1_rp)) begin
            dl_fwd = st2;
        end else if (r_lw_vld && (r_lw_addr == r1_rp)) begin
            dl_fwd = r_lw_data;
        end else begin
            dl_fwd = r_rd;
        end
    end
    assign dl1 = r1_dlok ? dl_fwd : t_sample'(0);

    assign g_s    = {1'b0, g_eff};
    assign g_prod = g_s * r2_dl;
    assign sum    = r2_a + g_prod;
    assign q_fl   = sum[SUM_W-1:FRAC_W];
    assign q      = (sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0))
                    ? q_fl + (SUM_W-FRAC_W)'(1) : q_fl;

    always_comb begin
        priority if (q > (SUM_W-FRAC_W)'(32767)) begin
            mix = t_sample'(16'sh7FFF);
        end else if (q < -(SUM_W-FRAC_W)'(32768)) begin
            mix = t_sample'(16'sh8000);
        end else begin
            mix = q[SAMPLE_W-1:0];
        end
    end

    assign y2  = r2_pass ? r2_x : mix;
    assign st2 = r2_fb ? y2 : r2_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_out_vld <= 1'b0;
            r_lw_vld  <= 1'b0;
        end else if (adv) begin
            r1_vld    <= acc;
            r2_vld    <= r1_vld;
            r_out_vld <= r2_vld;
            if (r2_vld) r_lw_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd    <= r_mem[rp_in];
            r1_x    <= x_in;
            r1_fb   <= r_fb;
            r1_pass <= !r_fb && pass;
            r1_curz <= !r_fb && cur_z;
            r1_dlok <= dl_ok;
            r1_rp   <= rp_in;
            r1_wp   <= r_wp;

            r2_x    <= r1_x;
            r2_fb   <= r1_fb;
            r2_pass <= r1_pass;
            r2_wp   <= r1_wp;
            r2_a    <= a_prod;
            r2_dl   <= dl1;

            r_out_data <= y2;
            if (r2_vld) begin
                r_mem[r2_wp] <= st2;
                r_lw_addr    <= r2_wp;
                r_lw_data    <= st2;
            end
        end
    end

    assign m_axis_tdata = r_out_data;

endmodule

FILE: hw/rtl/aecf_checker.sv
// Port-level checker for the echo comb filter, bound to the top level.
// Depends on aecf_pkg and audio_echo_comb_filter.
module aecf_checker
    import aecf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [SAMPLE_W-1:0] m_axis_tdata
);

    logic       in_beat;
    logic       out_beat;
    logic [2:0] r_pend;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(in_beat) - 3'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_pend != 3'd0)
        else $error("output beat without pending input beat");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd3)
        else $error("more than three beats in flight");

endmodule

bind audio_echo_comb_filter aecf_checker u_aecf_checker (.*);
